// File: rtl/modbus_request_framer_unit_macros.svh
// Assertion macros for the checker file of the Modbus request framer.
// No dependencies; include by bare file name.
`ifndef MODBUS_REQUEST_FRAMER_UNIT_MACROS_SVH
`define MODBUS_REQUEST_FRAMER_UNIT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define MRF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define MRF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mrf_pkg.sv
// Shared types, constants and the CRC step function of the Modbus request framer.
// No dependencies; used by mrf_csr and modbus_request_framer_unit.
package mrf_pkg;

   // Configuration port address width: two 32-bit registers at 0 and 4.
   localparam int CSR_ADDR_W = 3;

   // Modbus function codes that carry write data.
   localparam logic [7:0] FC_WRITE_SINGLE_COIL  = 8'h05;
   localparam logic [7:0] FC_WRITE_SINGLE_REG   = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI_COILS  = 8'h0F;
   localparam logic [7:0] FC_WRITE_MULTI_REGS   = 8'h10;

   // Modbus CRC-16, reflected form.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Register indexes of the configuration port.
   localparam logic REG_TCP_MODE = 1'b0;
   localparam logic REG_SLAVE    = 1'b1;

   typedef enum logic {
      OP_HEADER  = 1'b0,
      OP_PAYLOAD = 1'b1
   } op_type;

   // Byte positions of a frame; the sequencer walks through them.
   typedef enum logic [3:0] {
      SLOT_TID_HI,
      SLOT_TID_LO,
      SLOT_PROTO_HI,
      SLOT_PROTO_LO,
      SLOT_LEN_HI,
      SLOT_LEN_LO,
      SLOT_UNIT,
      SLOT_FUNC,
      SLOT_ADDR_HI,
      SLOT_ADDR_LO,
      SLOT_WORD_HI,
      SLOT_WORD_LO,
      SLOT_DATA,
      SLOT_CRC_LO,
      SLOT_CRC_HI
   } slot_type;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic       tcp_mode;
      logic [7:0] slave_address;
      logic       mode_flip;     // a write changes tcp_mode at this edge
   } cfg_type;

   // One byte of the Modbus CRC-16.
   function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/mrf_csr.sv
// Configuration registers (tcp_mode, slave_address) behind an APB-style port.
// Depends on mrf_pkg.
module mrf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mrf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output mrf_pkg::cfg_type               cfg
);

   logic       tcp_mode_ff;
   logic       tcp_mode_in;
   logic [7:0] slave_ff;
   logic [7:0] slave_in;
   logic       wr_en;
   logic       reg_idx;
   logic       flip;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[2];

   always_comb begin
      tcp_mode_in = tcp_mode_ff;
      slave_in    = slave_ff;
      flip        = 1'b0;
      if (wr_en) begin
         unique case (reg_idx)
            mrf_pkg::REG_TCP_MODE: begin
               tcp_mode_in = pwdata[0];
               flip        = pwdata[0] != tcp_mode_ff;
            end
            mrf_pkg::REG_SLAVE: begin
               slave_in = pwdata[7:0];
            end
            default: begin
               tcp_mode_in = tcp_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tcp_mode_ff <= 1'b0;
         slave_ff    <= 8'd1;
      end else begin
         tcp_mode_ff <= tcp_mode_in;
         slave_ff    <= slave_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         mrf_pkg::REG_TCP_MODE: prdata = {31'd0, tcp_mode_ff};
         mrf_pkg::REG_SLAVE:    prdata = {24'd0, slave_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.tcp_mode      = tcp_mode_ff;
   assign cfg.slave_address = slave_ff;
   assign cfg.mode_flip     = flip;

endmodule

// File: rtl/modbus_request_framer_unit.sv
// Modbus request framer top level: request register, byte sequencer, CRC and result register.
// Depends on mrf_pkg and mrf_csr.
//
//   Channel   Direction  Handshake          Moves
//   req_*     in         req_valid/ready    one header or payload byte request
//   rsp_*     out        rsp_valid/ready    one frame byte, frame_last on the final byte
//   csr       in/out     psel/penable       tcp_mode (0x0), slave_address (0x4)
//
// A payload byte request emits one byte; the final one of an RTU frame emits three
// (data byte and the two CRC bytes). A header request emits 4, 6 or 8 bytes in RTU mode,
// 10 or 12 in TCP mode. The result register takes one byte per cycle unless rsp_ready stalls it.
// Reset is synchronous and active high; it clears control state and loads register defaults.
// A stall on rsp_ready freezes the sequencer; req_ready falls only while the request
// register still holds bytes to emit.
module modbus_request_framer_unit #(
   parameter int MAX_PAYLOAD = 247
) (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mrf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [7:0]                     req_function_code,
   input  logic [15:0]                    req_start_address,
   input  logic [15:0]                    req_quantity,
   input  logic [7:0]                     req_payload_length,
   input  logic [7:0]                     req_payload_byte,
   // Result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_frame_byte,
   output logic                           rsp_frame_last
);

   localparam logic [7:0] MaxPayloadByte = 8'(MAX_PAYLOAD);

   mrf_pkg::cfg_type cfg;

   // Configuration registers sit in their own block; pready never stalls.
   mrf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready = 1'b1;

   // Frame state carried between requests.
   logic [15:0]       tid_ff, tid_in;
   logic [7:0]        remaining_ff, remaining_in;
   logic [15:0]       crc_ff, crc_in;

   // Request register: the request whose bytes are being emitted.
   logic              busy_ff, busy_in;
   mrf_pkg::slot_type slot_ff, slot_in;
   logic [7:0]        fc_ff;
   logic [15:0]       addr_ff;
   logic [15:0]       word_ff;
   logic              has_word_ff;
   logic [7:0]        pl_ff;
   logic              single_ff;
   logic              multi_ff;
   logic [7:0]        data_ff;
   logic              final_ff;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_last_ff;

   // Handshake and decode.
   logic              out_free;
   logic              issue;
   logic              item_done;
   logic              accept;
   logic              is_header;
   logic              load_item;
   logic              hdr_single;
   logic              hdr_multi;
   logic [7:0]        hdr_pl;
   logic [7:0]        hdr_wait;
   mrf_pkg::slot_type first_slot;

   // Sequencer.
   mrf_pkg::slot_type slot_next;
   logic              slot_last;
   logic [7:0]        cur_byte;
   logic [15:0]       len_word;
   logic [15:0]       crc_base;

   // The result register takes a byte whenever it is empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign issue     = busy_ff && out_free;
   assign item_done = issue && slot_last;
   // A new request enters while the last byte of the current one moves out.
   assign req_ready = !busy_ff || item_done;
   assign accept    = req_valid && req_ready;
   assign is_header = mrf_pkg::op_type'(req_operation) == mrf_pkg::OP_HEADER;

   // Header decode. Payload length is saturated; read codes await no payload.
   assign hdr_single = (req_function_code == mrf_pkg::FC_WRITE_SINGLE_COIL) ||
                       (req_function_code == mrf_pkg::FC_WRITE_SINGLE_REG);
   assign hdr_multi  = (req_function_code == mrf_pkg::FC_WRITE_MULTI_COILS) ||
                       (req_function_code == mrf_pkg::FC_WRITE_MULTI_REGS);
   assign hdr_pl     = (req_payload_length > MaxPayloadByte) ? MaxPayloadByte
                                                             : req_payload_length;
   assign hdr_wait   = (hdr_single || hdr_multi) ? hdr_pl : 8'd0;

   // A payload byte that nobody waits for is taken and dropped without a trace.
   assign load_item  = accept && (is_header || (remaining_ff != 8'd0));
   assign first_slot = !is_header     ? mrf_pkg::SLOT_DATA :
                       cfg.tcp_mode   ? mrf_pkg::SLOT_TID_HI : mrf_pkg::SLOT_UNIT;

   // Next byte position. After the last PDU byte of a frame, RTU appends the CRC.
   always_comb begin
      slot_next = slot_ff;
      slot_last = 1'b0;
      unique case (slot_ff)
         mrf_pkg::SLOT_TID_HI:   slot_next = mrf_pkg::SLOT_TID_LO;
         mrf_pkg::SLOT_TID_LO:   slot_next = mrf_pkg::SLOT_PROTO_HI;
         mrf_pkg::SLOT_PROTO_HI: slot_next = mrf_pkg::SLOT_PROTO_LO;
         mrf_pkg::SLOT_PROTO_LO: slot_next = mrf_pkg::SLOT_LEN_HI;
         mrf_pkg::SLOT_LEN_HI:   slot_next = mrf_pkg::SLOT_LEN_LO;
         mrf_pkg::SLOT_LEN_LO:   slot_next = mrf_pkg::SLOT_UNIT;
         mrf_pkg::SLOT_UNIT:     slot_next = mrf_pkg::SLOT_FUNC;
         mrf_pkg::SLOT_FUNC:     slot_next = mrf_pkg::SLOT_ADDR_HI;
         mrf_pkg::SLOT_ADDR_HI:  slot_next = mrf_pkg::SLOT_ADDR_LO;
         mrf_pkg::SLOT_ADDR_LO: begin
            if (has_word_ff) begin
               slot_next = mrf_pkg::SLOT_WORD_HI;
            end else if (final_ff && !cfg.tcp_mode) begin
               slot_next = mrf_pkg::SLOT_CRC_LO;
            end else begin
               slot_last = 1'b1;
            end
         end
         mrf_pkg::SLOT_WORD_HI:  slot_next = mrf_pkg::SLOT_WORD_LO;
         mrf_pkg::SLOT_WORD_LO, mrf_pkg::SLOT_DATA: begin
            if (final_ff && !cfg.tcp_mode) begin
               slot_next = mrf_pkg::SLOT_CRC_LO;
            end else begin
               slot_last = 1'b1;
            end
         end
         mrf_pkg::SLOT_CRC_LO:   slot_next = mrf_pkg::SLOT_CRC_HI;
         mrf_pkg::SLOT_CRC_HI:   slot_last = 1'b1;
         default:                slot_last = 1'b1;
      endcase
   end

   // MBAP length field counts the unit id and the PDU.
   always_comb begin
      if (single_ff) begin
         len_word = 16'd4 + ((pl_ff == 8'd0) ? 16'd2 : {8'd0, pl_ff});
      end else if (multi_ff) begin
         len_word = 16'd6 + {8'd0, pl_ff};
      end else begin
         len_word = 16'd6;
      end
   end

   // Byte value at the current position.
   always_comb begin
      unique case (slot_ff)
         mrf_pkg::SLOT_TID_HI:   cur_byte = tid_ff[15:8];
         mrf_pkg::SLOT_TID_LO:   cur_byte = tid_ff[7:0];
         mrf_pkg::SLOT_PROTO_HI: cur_byte = 8'h00;
         mrf_pkg::SLOT_PROTO_LO: cur_byte = 8'h00;
         mrf_pkg::SLOT_LEN_HI:   cur_byte = len_word[15:8];
         mrf_pkg::SLOT_LEN_LO:   cur_byte = len_word[7:0];
         mrf_pkg::SLOT_UNIT:     cur_byte = cfg.slave_address;
         mrf_pkg::SLOT_FUNC:     cur_byte = fc_ff;
         mrf_pkg::SLOT_ADDR_HI:  cur_byte = addr_ff[15:8];
         mrf_pkg::SLOT_ADDR_LO:  cur_byte = addr_ff[7:0];
         mrf_pkg::SLOT_WORD_HI:  cur_byte = word_ff[15:8];
         mrf_pkg::SLOT_WORD_LO:  cur_byte = word_ff[7:0];
         mrf_pkg::SLOT_DATA:     cur_byte = data_ff;
         mrf_pkg::SLOT_CRC_LO:   cur_byte = crc_ff[7:0];
         mrf_pkg::SLOT_CRC_HI:   cur_byte = crc_ff[15:8];
         default:                cur_byte = 8'h00;
      endcase
   end

   // The CRC restarts on the first byte of every header and is frozen while
   // its own two bytes go out. In TCP mode it runs along unused.
   assign crc_base = ((slot_ff == mrf_pkg::SLOT_TID_HI) || (slot_ff == mrf_pkg::SLOT_UNIT))
                     ? mrf_pkg::CRC_INIT : crc_ff;

   always_comb begin
      crc_in = crc_ff;
      if (issue && (slot_ff != mrf_pkg::SLOT_CRC_LO) && (slot_ff != mrf_pkg::SLOT_CRC_HI)) begin
         crc_in = mrf_pkg::crc_feed(crc_base, cur_byte);
      end
   end

   // Frame state updates at request acceptance; a mode change abandons the frame.
   always_comb begin
      tid_in       = tid_ff;
      remaining_in = remaining_ff;
      if (cfg.mode_flip) begin
         tid_in       = 16'd0;
         remaining_in = 8'd0;
      end else if (accept && is_header) begin
         remaining_in = hdr_wait;
         if (cfg.tcp_mode) begin
            tid_in = tid_ff + 16'd1;
         end
      end else if (accept && (remaining_ff != 8'd0)) begin
         remaining_in = remaining_ff - 8'd1;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (load_item) begin
         busy_in = 1'b1;
         slot_in = first_slot;
      end else if (item_done) begin
         busy_in = 1'b0;
      end else if (issue) begin
         slot_in = slot_next;
      end
   end

   assign rsp_valid_in = out_free ? issue : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tid_ff       <= 16'd0;
         remaining_ff <= 8'd0;
         crc_ff       <= mrf_pkg::CRC_INIT;
         busy_ff      <= 1'b0;
         slot_ff      <= mrf_pkg::SLOT_UNIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         tid_ff       <= tid_in;
         remaining_ff <= remaining_in;
         crc_ff       <= crc_in;
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload registers.
   always_ff @(posedge clock) begin
      if (load_item) begin
         fc_ff   <= req_function_code;
         addr_ff <= req_start_address;
         data_ff <= req_payload_byte;
         if (is_header) begin
            single_ff   <= hdr_single;
            multi_ff    <= hdr_multi;
            pl_ff       <= hdr_pl;
            // Write-single with no payload sends two zero bytes in place of the data.
            has_word_ff <= !hdr_single || (hdr_pl == 8'd0);
            word_ff     <= hdr_single ? 16'd0 : req_quantity;
            final_ff    <= hdr_wait == 8'd0;
         end else begin
            final_ff    <= remaining_ff == 8'd1;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= slot_last && final_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// File: rtl/mrf_checker.sv
// Port-level checker for the Modbus request framer, bound to the top level.
// Depends on modbus_request_framer_unit_macros.svh.
`include "modbus_request_framer_unit_macros.svh"

module mrf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A result that is not taken stays offered.
   `MRF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // Reset empties the result register.
   `MRF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result offered right after reset")

   // With nothing offered and nothing taken in the previous cycle, no request is in flight.
   `MRF_ASSERT(a_idle_ready, clock, reset, !rsp_valid && !$past(req_valid && req_ready) |-> req_ready, "framer stuck without output")

endmodule

bind modbus_request_framer_unit mrf_checker u_mrf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);
